// ===== src/assert_macros.svh =====
// Assertion shorthands shared by the RTL. Each macro expects the module to
// have the ports i_clk and i_rst_n, and checks nothing while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ust_pkg.sv =====
package ust_pkg;

    // Field widths of the request and result channels.
    localparam int FUNC_W     = 2;
    localparam int KEY_W      = 32;
    localparam int POS_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int MATCH_W    = 6;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SEARCH = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_ERASE  = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands broadcast to every cell of the row.
    typedef struct packed {
        logic cmp;   // compare the key and the read position, latch the flags
        logic ins;   // append the key at the cell whose index equals the count
        logic ers;   // cells at or above the match take their upper neighbor
    } t_cell_ctrl;

endpackage

// ===== src/ust_cell.sv =====
module ust_cell #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int IDX_W         = 6,
    parameter int CNT_W         = 7
) (
    input  logic                       i_clk,
    input  ust_pkg::t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]           i_index,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [ELEMENT_WIDTH-1:0]   i_key,
    input  logic [ust_pkg::POS_W-1:0]  i_position,
    input  logic [IDX_W-1:0]           i_match_idx,
    input  logic [ELEMENT_WIDTH-1:0]   i_next_value,
    output logic [ELEMENT_WIDTH-1:0]   o_value,
    output logic                       o_hit,
    output logic                       o_sel
);
    import ust_pkg::*;

    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [ELEMENT_WIDTH-1:0] r_value;
    logic                     r_hit;
    logic                     r_sel;
    logic                     w_live;
    logic                     w_at_pos;

    // The entry is live when its index lies below the current count.
    assign w_live   = CNT_W'(i_index) < i_count;
    assign w_at_pos = CMP_W'(i_index) == CMP_W'(i_position);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_hit <= w_live && (r_value == i_key);
            r_sel <= w_live && w_at_pos;
        end
    end

    // Most cycles neither an append nor a shift reaches this cell, and the
    // entry simply holds.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && (CNT_W'(i_index) == i_count)) begin
            r_value <= i_key;
        end else if (i_ctrl.ers && (i_index >= i_match_idx)) begin
            r_value <= i_next_value;
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;
    assign o_sel   = r_sel;

endmodule

// ===== src/unsorted_set_table_core.sv =====
// Set of distinct values held in an unsorted row of CAPACITY cells with a live
// count. The operation travels in s_axis_tuser: search reports whether the key
// is present and where, insert appends an absent key (or reports full), erase
// removes a present key and slides every later entry down one cell so the
// order is kept, and read returns the entry at a position below the count.
// Every request gives exactly one result. In the cycle a request is accepted
// every cell compares its entry against the key and its index against the
// read position; once the output register is free, the latched match flags
// are combined, the row is updated in one step, and the result is loaded into
// the output register. Only then is a new request accepted, so the block
// cannot take a new request before it is through with the last one; a result
// waiting in the output register does not block the next request from being
// accepted, only its second step. Keys are cut to the lesser of ELEMENT_WIDTH
// and 32 bits before they are compared or stored. The entries need no
// clearing after reset, since only cells below the count are ever looked at.
`include "assert_macros.svh"

module unsorted_set_table_core #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: key_value[31:0], position[37:32], zero padding.
    input  logic [ust_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [ust_pkg::FUNC_W-1:0]     s_axis_tuser,
    // Result channel.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: match_position[5:0], read_value[37:6],
    // entry_count[44:38], zero padding.
    output logic [ust_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [ust_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import ust_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Key bits that survive both the 32-bit field and the element width.
    localparam int KW    = (ELEMENT_WIDTH < KEY_W) ? ELEMENT_WIDTH : KEY_W;

    // Control state.
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;

    // Request held for the execute state.
    t_func                    r_func;
    logic [ELEMENT_WIDTH-1:0] r_key;

    // Result register.
    t_status             r_out_status;
    logic [MATCH_W-1:0]  r_out_match;
    logic [VALUE_W-1:0]  r_out_value;
    logic [COUNT_W-1:0]  r_out_count;

    // Handshake and row control.
    logic                     w_accept;
    logic                     w_finish;
    t_cell_ctrl               w_ctrl;
    logic [ELEMENT_WIDTH-1:0] w_in_key;
    logic [ELEMENT_WIDTH-1:0] w_cell_key;

    // What the cell row reports.
    logic [CAPACITY-1:0]      w_hit_vec;
    logic [CAPACITY-1:0]      w_sel_vec;
    logic [ELEMENT_WIDTH-1:0] w_cell_value [CAPACITY];
    logic                     w_found;
    logic [IDX_W-1:0]         w_match_idx;
    logic [ELEMENT_WIDTH-1:0] w_read_elem;
    logic                     w_has_room;

    // Result of the request in the execute state.
    t_status                  w_status;
    logic [MATCH_W-1:0]       w_match;
    logic [VALUE_W-1:0]       w_value;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    // The execute state completes only when the output register is free.
    assign w_finish = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_in_key         = '0;
        w_in_key[KW-1:0] = s_axis_tdata[KW-1:0];
    end

    // ------------------------------------------------------------------
    // Cell row. Each cell holds one entry and takes its upper neighbor's
    // value when an erase closes the gap below it.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] w_next_value;

        if (g == CAPACITY - 1) begin : g_last
            assign w_next_value = w_cell_value[g];
        end else begin : g_inner
            assign w_next_value = w_cell_value[g + 1];
        end

        ust_cell #(
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .IDX_W         (IDX_W),
            .CNT_W         (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_index      (IDX_W'(g)),
            .i_count      (r_count),
            .i_key        (w_cell_key),
            .i_position   (s_axis_tdata[KEY_W +: POS_W]),
            .i_match_idx  (w_match_idx),
            .i_next_value (w_next_value),
            .o_value      (w_cell_value[g]),
            .o_hit        (w_hit_vec[g]),
            .o_sel        (w_sel_vec[g])
        );
    end

    // The set holds distinct values and only one cell sits at the read
    // position, so each flag vector has at most one bit set and a plain OR
    // over the cells recovers the matching index and the selected entry.
    always_comb begin
        w_match_idx = '0;
        w_read_elem = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_match_idx = w_match_idx | (w_hit_vec[i] ? IDX_W'(i) : '0);
            w_read_elem = w_read_elem | (w_sel_vec[i] ? w_cell_value[i] : '0);
        end
    end

    assign w_found    = |w_hit_vec;
    assign w_has_room = r_count < CNT_W'(CAPACITY);

    // ------------------------------------------------------------------
    // Result and new count for the request in the execute state.
    // ------------------------------------------------------------------
    always_comb begin
        w_status = ST_OK;
        w_match  = '0;
        w_value  = '0;
        n_count  = r_count;
        unique case (r_func)
            FUNC_SEARCH: begin
                if (w_found) begin
                    w_match = MATCH_W'(w_match_idx);
                end else begin
                    w_status = ST_MISS;
                end
            end
            FUNC_INSERT: begin
                // The duplicate check wins over the full check.
                priority if (w_found) begin
                    w_status = ST_MISS;
                end else if (!w_has_room) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_ERASE: begin
                if (w_found) begin
                    w_match = MATCH_W'(w_match_idx);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_status = ST_MISS;
                end
            end
            FUNC_READ: begin
                if (|w_sel_vec) begin
                    w_value[KW-1:0] = w_read_elem[KW-1:0];
                end else begin
                    w_status = ST_BAD_POS;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        // Compare against the incoming key; write the latched one.
        w_cell_key    = (r_state == S_IDLE) ? w_in_key : r_key;
        w_ctrl.cmp    = w_accept;
        w_ctrl.ins    = w_finish && (r_func == FUNC_INSERT) && !w_found && w_has_room;
        w_ctrl.ers    = w_finish && (r_func == FUNC_ERASE) && w_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= t_func'(s_axis_tuser);
            r_key  <= w_in_key;
        end
        if (w_finish) begin
            r_out_status <= w_status;
            r_out_match  <= w_match;
            r_out_value  <= w_value;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(OUT_DATA_W - MATCH_W - VALUE_W - COUNT_W){1'b0}},
                            r_out_count, r_out_value, r_out_match};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(CAPACITY), "count beyond capacity")
    `ASSERT_ALWAYS(a_hit_unique, (r_state != S_EXEC) || $onehot0(w_hit_vec), "key in two cells")
    `ASSERT_ALWAYS(a_sel_unique, (r_state != S_EXEC) || $onehot0(w_sel_vec), "two cells selected")
    `ASSERT_NEXT(a_count_hold, !w_finish, $stable(r_count), "count moved without a request")
    `ASSERT_NEXT(a_result_loaded, w_finish, m_axis_tvalid, "finished request gave no result")

endmodule
